// ===== rtl/rsnt_pkg.sv =====
// Shared types and constants for the ring search nearest tile block.
package rsnt_pkg;

    localparam int COORD_W   = 7;
    localparam int HEIGHT_W  = 8;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_DATA_W-1:0] SIDE_LIMIT = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LEVEL = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [HEIGHT_W-1:0] DIG_LIMIT  = 8'd1;
    localparam logic [HEIGHT_W-1:0] FILL_LIMIT = 8'd255;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic                operation;
        coord_t              tile_x;
        coord_t              tile_z;
        logic [HEIGHT_W-1:0] tile_height;
        logic                tile_planned;
        logic                want_planned;
        logic                want_above;
    } item_t;

    typedef struct packed {
        logic   found;
        coord_t found_x;
        coord_t found_z;
    } result_t;

    typedef struct packed {
        logic                planned;
        logic [HEIGHT_W-1:0] height;
    } tile_t;

    typedef struct packed {
        logic   launch;
        logic   abort;
        coord_t cx;
        coord_t cz;
        coord_t wl;
        coord_t dl;
    } walk_ctl_t;

    typedef struct packed {
        logic   busy;
        logic   issue;
        coord_t x;
        coord_t z;
    } walk_sts_t;

endpackage

// ===== rtl/rsnt_walker.sv =====
// Address sequencer that walks the centre and then the clamped square rings.
module rsnt_walker (
    input  logic              clk,
    input  logic              rst_n,
    input  rsnt_pkg::walk_ctl_t ctl,
    output rsnt_pkg::walk_sts_t sts
);
    import rsnt_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_CENTRE = 4'd2;
    localparam logic [3:0] ST_RING   = 4'd3;
    localparam logic [3:0] ST_TOP    = 4'd4;
    localparam logic [3:0] ST_RIGHT  = 4'd5;
    localparam logic [3:0] ST_BOTTOM = 4'd6;
    localparam logic [3:0] ST_LEFT   = 4'd7;

    logic [3:0] state_reg, state_next;
    coord_t cx_reg, cx_next, cz_reg, cz_next;
    coord_t wl_reg, wl_next, dl_reg, dl_next;
    coord_t maxr_reg, maxr_next, r_reg, r_next;
    coord_t lux_reg, lux_next, luz_reg, luz_next;
    coord_t rdx_reg, rdx_next, rdz_reg, rdz_next;
    logic signed [COORD_W+1:0] cur_x_reg, cur_x_next, cur_z_reg, cur_z_next;

    coord_t ring_lux, ring_luz, ring_rdx, ring_rdz;
    logic [COORD_W:0] sum_x, sum_z;
    coord_t dist_r, dist_b, max_a, max_b;
    logic issue;
    coord_t issue_x, issue_z;

    function automatic logic signed [COORD_W+1:0] ext(input coord_t v);
        ext = $signed({2'b00, v});
    endfunction

    always_comb
    begin
        sum_x    = {1'b0, cx_reg} + {1'b0, r_reg};
        sum_z    = {1'b0, cz_reg} + {1'b0, r_reg};
        ring_lux = (cx_reg >= r_reg) ? cx_reg - r_reg : '0;
        ring_luz = (cz_reg >= r_reg) ? cz_reg - r_reg : '0;
        ring_rdx = (sum_x > {1'b0, wl_reg}) ? wl_reg : sum_x[COORD_W-1:0];
        ring_rdz = (sum_z > {1'b0, dl_reg}) ? dl_reg : sum_z[COORD_W-1:0];
        dist_r   = wl_reg - cx_reg;
        dist_b   = dl_reg - cz_reg;
        max_a    = (dist_r > cx_reg) ? dist_r : cx_reg;
        max_b    = (dist_b > cz_reg) ? dist_b : cz_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cz_next    = cz_reg;
        wl_next    = wl_reg;
        dl_next    = dl_reg;
        maxr_next  = maxr_reg;
        r_next     = r_reg;
        lux_next   = lux_reg;
        luz_next   = luz_reg;
        rdx_next   = rdx_reg;
        rdz_next   = rdz_reg;
        cur_x_next = cur_x_reg;
        cur_z_next = cur_z_reg;
        issue      = 1'b0;
        issue_x    = '0;
        issue_z    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.launch)
                begin
                    cx_next    = ctl.cx;
                    cz_next    = ctl.cz;
                    wl_next    = ctl.wl;
                    dl_next    = ctl.dl;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                maxr_next  = (max_a > max_b) ? max_a : max_b;
                state_next = ST_CENTRE;
            end
            ST_CENTRE:
            begin
                issue   = 1'b1;
                issue_x = cx_reg;
                issue_z = cz_reg;
                if (maxr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next     = coord_t'(1);
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                lux_next   = ring_lux;
                luz_next   = ring_luz;
                rdx_next   = ring_rdx;
                rdz_next   = ring_rdz;
                cur_x_next = ext(ring_lux) + 9'sd1;
                state_next = ST_TOP;
            end
            ST_TOP:
            begin
                if (cur_x_reg <= ext(rdx_reg))
                begin
                    issue      = 1'b1;
                    issue_x    = cur_x_reg[COORD_W-1:0];
                    issue_z    = luz_reg;
                    cur_x_next = cur_x_reg + 9'sd1;
                end
                else
                begin
                    cur_z_next = ext(luz_reg) + 9'sd1;
                    state_next = ST_RIGHT;
                end
            end
            ST_RIGHT:
            begin
                if (cur_z_reg <= ext(rdz_reg))
                begin
                    issue      = 1'b1;
                    issue_x    = rdx_reg;
                    issue_z    = cur_z_reg[COORD_W-1:0];
                    cur_z_next = cur_z_reg + 9'sd1;
                end
                else
                begin
                    cur_x_next = ext(rdx_reg) - 9'sd1;
                    state_next = ST_BOTTOM;
                end
            end
            ST_BOTTOM:
            begin
                if (cur_x_reg >= ext(lux_reg))
                begin
                    issue      = 1'b1;
                    issue_x    = cur_x_reg[COORD_W-1:0];
                    issue_z    = rdz_reg;
                    cur_x_next = cur_x_reg - 9'sd1;
                end
                else
                begin
                    cur_z_next = ext(rdz_reg) - 9'sd1;
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:
            begin
                if (cur_z_reg >= ext(luz_reg))
                begin
                    issue      = 1'b1;
                    issue_x    = lux_reg;
                    issue_z    = cur_z_reg[COORD_W-1:0];
                    cur_z_next = cur_z_reg - 9'sd1;
                end
                else if (r_reg == maxr_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next     = r_reg + coord_t'(1);
                    state_next = ST_RING;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (ctl.abort)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cz_reg    <= cz_next;
        wl_reg    <= wl_next;
        dl_reg    <= dl_next;
        maxr_reg  <= maxr_next;
        r_reg     <= r_next;
        lux_reg   <= lux_next;
        luz_reg   <= luz_next;
        rdx_reg   <= rdx_next;
        rdz_reg   <= rdz_next;
        cur_x_reg <= cur_x_next;
        cur_z_reg <= cur_z_next;
    end

    assign sts.busy  = (state_reg != ST_IDLE);
    assign sts.issue = issue;
    assign sts.x     = issue_x;
    assign sts.z     = issue_z;

endmodule

// ===== rtl/ring_search_nearest_tile.sv =====
// Top level of the ring search nearest tile block: tile memory, match logic and result register.
//
// Usage. Items arrive on item with start; one is taken at a clock edge where start is high
// and busy is low. A write item (operation 0) stores a height and planned bit in the tile
// memory and returns a result with found low on done, registered at the accepting edge.
// A search item (operation 1) tests the centre tile and then walks clamped square rings of
// growing radius, returning the first matching tile, or found low if none matches.
// The tile memory has one synchronous read port and is read one tile per cycle; that port
// sets the search time, which grows with every ring walked and every tile read on it,
// where a ring clamped at a map edge reads again tiles that an earlier ring read. Busy
// stays high for the whole search, so items are taken one at a time. Each result appears
// on result for exactly one cycle with done high; the receiver cannot stall it.
// Registers are written on the cfg channel (cfg_ready is always high): index 0 map width,
// 1 map depth, 2 zero layer level. The user must write them only while the block is idle;
// the block itself does not enforce this.
// Reset sets the map to 128 by 128 and the zero layer to 0 and stops any search; tile
// contents are undefined until written, and searches must only read written tiles.
module ring_search_nearest_tile (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rsnt_pkg::item_t                      item,
    output logic                                 done,
    output rsnt_pkg::result_t                    result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rsnt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsnt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rsnt_pkg::*;

    logic [CFG_DATA_W-1:0] map_width_reg, map_depth_reg, zero_level_reg;
    logic search_active_reg, search_active_next;
    logic rd_valid_reg;
    coord_t rd_x_reg, rd_z_reg;
    tile_t rd_data_reg;
    logic want_planned_reg, want_above_reg;
    logic done_reg, done_next;
    result_t result_reg, result_next;

    tile_t tile_mem [STORE_DEPTH];

    logic accept, write_op, search_op;
    coord_t wl, dl, cx, cz;
    logic match, hit, miss_end;
    walk_ctl_t ctl;
    walk_sts_t sts;

    assign accept    = start && !busy;
    assign write_op  = accept && (item.operation == OP_WRITE);
    assign search_op = accept && (item.operation == OP_SEARCH);

    always_comb
    begin
        if (map_width_reg == '0)
        begin
            wl = '0;
        end
        else if (map_width_reg > SIDE_LIMIT)
        begin
            wl = coord_t'(SIDE_LIMIT - 8'd1);
        end
        else
        begin
            wl = coord_t'(map_width_reg - 8'd1);
        end
        if (map_depth_reg == '0)
        begin
            dl = '0;
        end
        else if (map_depth_reg > SIDE_LIMIT)
        begin
            dl = coord_t'(SIDE_LIMIT - 8'd1);
        end
        else
        begin
            dl = coord_t'(map_depth_reg - 8'd1);
        end
        cx = (item.tile_x > wl) ? wl : item.tile_x;
        cz = (item.tile_z > dl) ? dl : item.tile_z;
    end

    always_comb
    begin
        if (rd_data_reg.planned != want_planned_reg)
        begin
            match = 1'b0;
        end
        else if (want_planned_reg)
        begin
            match = want_above_reg ? (rd_data_reg.height > zero_level_reg)
                                   : (rd_data_reg.height < zero_level_reg);
        end
        else
        begin
            match = want_above_reg ? (rd_data_reg.height > DIG_LIMIT)
                                   : (rd_data_reg.height < FILL_LIMIT);
        end
    end

    assign hit      = search_active_reg && rd_valid_reg && match;
    assign miss_end = search_active_reg && !rd_valid_reg && !sts.busy;

    assign ctl.launch = search_op;
    assign ctl.abort  = hit;
    assign ctl.cx     = cx;
    assign ctl.cz     = cz;
    assign ctl.wl     = wl;
    assign ctl.dl     = dl;

    rsnt_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts)
    );

    always_comb
    begin
        search_active_next = search_active_reg;
        if (search_op)
        begin
            search_active_next = 1'b1;
        end
        else if (hit || miss_end)
        begin
            search_active_next = 1'b0;
        end
        done_next           = write_op || hit || miss_end;
        result_next.found   = hit;
        result_next.found_x = hit ? rd_x_reg : '0;
        result_next.found_z = hit ? rd_z_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (write_op)
        begin
            tile_mem[{item.tile_z, item.tile_x}] <= '{planned: item.tile_planned,
                                                      height: item.tile_height};
        end
        rd_data_reg <= tile_mem[{sts.z, sts.x}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg     <= SIDE_LIMIT;
            map_depth_reg     <= SIDE_LIMIT;
            zero_level_reg    <= '0;
            search_active_reg <= 1'b0;
            rd_valid_reg      <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    CFG_MAP_DEPTH:  map_depth_reg  <= cfg_data;
                    CFG_ZERO_LEVEL: zero_level_reg <= cfg_data;
                    default:        ;
                endcase
            end
            search_active_reg <= search_active_next;
            rd_valid_reg      <= sts.issue && !hit;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg   <= sts.x;
        rd_z_reg   <= sts.z;
        result_reg <= result_next;
        if (search_op)
        begin
            want_planned_reg <= item.want_planned;
            want_above_reg   <= item.want_above;
        end
    end

    assign busy      = search_active_reg;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

endmodule
